// File: rtl/arcball_drag_rotation_unit_macros.svh
// Assertion macros for the arcball drag rotation unit.
// Included by the top level; no other dependencies.
`ifndef ARCBALL_DRAG_ROTATION_UNIT_MACROS_SVH
`define ARCBALL_DRAG_ROTATION_UNIT_MACROS_SVH
// Assert a property on clk, disabled in reset.
`define ADR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition implies another in the next cycle.
`define ADR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

// File: rtl/adr_pkg.sv
// Package for the arcball drag rotation unit: payload types and constants.
// No dependencies.
`default_nettype none
package adr_pkg;
  localparam int CoordBits = 12;
  localparam int FracBits = 14;
  localparam int SqGuard = 31 - CoordBits;

  localparam logic [1:0] REQ_PRESS = 2'd0;
  localparam logic [1:0] REQ_MOVE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_CANVAS_H = 3'd3;
  localparam logic [2:0] CFG_FLIP_Y = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic signed [15:0] arc_start_x;
    logic signed [15:0] arc_start_y;
    logic signed [15:0] arc_end_x;
    logic signed [15:0] arc_end_y;
    logic signed [15:0] arc_end_z;
    logic is_dragging;
  } out_item_t;

  // Operation codes for the shared divide / root unit.
  typedef enum logic {DU_DIV, DU_SQRT} du_op_t;
endpackage
`default_nettype wire

// File: rtl/adr_divsqrt.sv
// Shared multicycle unit: unsigned 64-bit restoring divide or floor square root.
// Uses adr_pkg for the operation code.
`default_nettype none
module adr_divsqrt (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire adr_pkg::du_op_t op,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic busy,
  output logic [63:0] res
);
  import adr_pkg::*;

  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, num_r, num_nxt, den_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r;
  du_op_t op_r;
  logic [64:0] trial;
  logic [65:0] strial;
  logic [63:0] srem;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    trial = '0;
    strial = '0;
    srem = '0;
    if (op_r == DU_DIV) begin
      // one quotient bit a cycle
      trial = {rem_r, num_r[63]};
      num_nxt = {num_r[62:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 64'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end else begin
      // one root bit a cycle from two radicand bits
      srem = {rem_r[61:0], num_r[63:62]};
      num_nxt = {num_r[61:0], 2'b00};
      strial = {2'b00, srem} - {quo_r[62:0], 2'b01};
      if (!strial[65]) begin
        rem_nxt = strial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = srem;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
    cnt_nxt = cnt_r - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      op_r <= op;
      num_r <= a;
      den_r <= b;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= (op == DU_DIV) ? 7'd64 : 7'd32;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      num_r <= num_nxt;
      cnt_r <= cnt_nxt;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign res = quo_r;
endmodule
`default_nettype wire

// File: rtl/arcball_drag_rotation_unit.sv
// Arcball drag rotation unit. One request (press, move, release) at a time.
// The time a request takes is set by the bit-serial divide and square-root unit
// (a move while dragging inside the ball needs one root and three divides for
// the sphere point, then one root and two divides for the arc start) and by the
// one shared multiplier that walks the cross, dot and quaternion products of a
// drag move and then the arc terms, one term per cycle. A release with a press
// rotation of zero x and y is the shortest case. After the result is taken the
// unit returns to idle before it accepts the next request. in_stall is high
// from acceptance until the result is taken.
// Depends on adr_pkg, adr_divsqrt and the assertion macro header.
`default_nettype none
`include "arcball_drag_rotation_unit_macros.svh"
module arcball_drag_rotation_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire adr_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output adr_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [11:0] cfg_data
);
  import adr_pkg::*;

  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  typedef enum logic [4:0] {
    S_IDLE, S_CUR, S_M2, S_MW, S_SQ, S_SQW, S_D0, S_D0W, S_D1, S_D1W, S_D2, S_D2W,
    S_CROSS, S_QMUL, S_AS, S_ASW, S_FX, S_FXW, S_FY, S_FYW, S_ARC, S_OUT
  } state_t;

  state_t state_r;
  logic [11:0] cx_r, cy_r, rad_r, ch_r;
  logic flip_r;
  logic [1:0] req_r;
  logic [11:0] cur_x_r, cur_y_r;
  logic signed [31:0] pp_r [3];
  logic signed [31:0] t_r [3];
  logic signed [31:0] pr_r [4];
  logic signed [31:0] cr_r [4];
  logic signed [31:0] d_r [4];
  logic drag_r;
  logic outside_r;
  logic [63:0] m2_r, nrm_r;
  logic signed [63:0] acc_r;
  logic [3:0] step_r;
  logic [1:0] idx_r;
  logic signed [31:0] fx_r, fy_r, ex_r, ey_r, ez_r;
  logic out_valid_r;

  // shared divide / root unit
  logic du_start;
  du_op_t du_op;
  logic [63:0] du_a, du_b, du_res;
  logic du_busy;

  adr_divsqrt u_du (
    .clk(clk), .rst_n(rst_n), .start(du_start), .op(du_op),
    .a(du_a), .b(du_b), .busy(du_busy), .res(du_res)
  );

  function automatic logic signed [31:0] clampq(input logic signed [63:0] v);
    if (v > 64'(One)) return One;
    if (v < -64'(One)) return -One;
    return 32'(v);
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + 64'(One >>> 1);
    return b >>> FracBits;
  endfunction

  function automatic logic [15:0] out16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'h7fff;
    if (v < -32'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  // radius, zero treated as one
  logic [11:0] rad_e;
  assign rad_e = (rad_r == '0) ? 12'd1 : rad_r;
  logic signed [12:0] dx, dy;
  assign dx = $signed({1'b0, cur_x_r}) - $signed({1'b0, cx_r});
  assign dy = $signed({1'b0, cur_y_r}) - $signed({1'b0, cy_r});
  logic [63:0] r2;
  assign r2 = 64'({12'd0, rad_e} * {12'd0, rad_e});

  // signed quotient truncated toward zero via magnitudes
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction
  logic neg_r;

  // shared multiplier: operands chosen by step
  logic signed [31:0] ma, mb;
  logic sub;
  logic signed [63:0] prod;
  assign prod = ma * mb;

  always_comb begin
    ma = '0;
    mb = '0;
    sub = 1'b0;
    if (state_r == S_CROSS) begin
      case (idx_r)
        2'd0: begin
          ma = step_r[0] ? pp_r[2] : pp_r[1];
          mb = step_r[0] ? t_r[1] : t_r[2];
          sub = step_r[0];
        end
        2'd1: begin
          ma = step_r[0] ? pp_r[0] : pp_r[2];
          mb = step_r[0] ? t_r[2] : t_r[0];
          sub = step_r[0];
        end
        2'd2: begin
          ma = step_r[0] ? pp_r[1] : pp_r[0];
          mb = step_r[0] ? t_r[0] : t_r[1];
          sub = step_r[0];
        end
        default: begin
          ma = pp_r[step_r[1:0]];
          mb = t_r[step_r[1:0]];
        end
      endcase
    end else if (state_r == S_QMUL) begin
      case (idx_r)
        2'd0: case (step_r[1:0])
          2'd0: begin ma = d_r[3]; mb = pr_r[0]; end
          2'd1: begin ma = d_r[0]; mb = pr_r[3]; end
          2'd2: begin ma = d_r[1]; mb = pr_r[2]; end
          default: begin ma = d_r[2]; mb = pr_r[1]; sub = 1'b1; end
        endcase
        2'd1: case (step_r[1:0])
          2'd0: begin ma = d_r[3]; mb = pr_r[1]; end
          2'd1: begin ma = d_r[1]; mb = pr_r[3]; end
          2'd2: begin ma = d_r[2]; mb = pr_r[0]; end
          default: begin ma = d_r[0]; mb = pr_r[2]; sub = 1'b1; end
        endcase
        2'd2: case (step_r[1:0])
          2'd0: begin ma = d_r[3]; mb = pr_r[2]; end
          2'd1: begin ma = d_r[2]; mb = pr_r[3]; end
          2'd2: begin ma = d_r[0]; mb = pr_r[1]; end
          default: begin ma = d_r[1]; mb = pr_r[0]; sub = 1'b1; end
        endcase
        default: case (step_r[1:0])
          2'd0: begin ma = d_r[3]; mb = pr_r[3]; end
          2'd1: begin ma = d_r[0]; mb = pr_r[0]; sub = 1'b1; end
          2'd2: begin ma = d_r[1]; mb = pr_r[1]; sub = 1'b1; end
          default: begin ma = d_r[2]; mb = pr_r[2]; sub = 1'b1; end
        endcase
      endcase
    end else if (state_r == S_ARC) begin
      case (idx_r)
        2'd0: begin
          ma = step_r[0] ? pr_r[2] : pr_r[3];
          mb = step_r[0] ? fy_r : fx_r;
          sub = step_r[0];
        end
        2'd1: begin
          ma = step_r[0] ? pr_r[2] : pr_r[3];
          mb = step_r[0] ? fx_r : fy_r;
        end
        default: begin
          ma = step_r[0] ? pr_r[1] : pr_r[0];
          mb = step_r[0] ? fx_r : fy_r;
          sub = step_r[0];
        end
      endcase
    end else if (state_r == S_AS) begin
      ma = step_r[0] ? pr_r[1] : pr_r[0];
      mb = ma;
    end
  end

  logic signed [63:0] acc_sum;
  assign acc_sum = sub ? acc_r - prod : acc_r + prod;
  logic last_cross, last_qmul;
  assign last_cross = (idx_r == 2'd3) ? (step_r == 4'd2) : (step_r == 4'd1);
  assign last_qmul = (step_r == 4'd3);

  logic [11:0] fy_in;
  assign fy_in = (in_data.pos_y > ch_r) ? 12'd0 : 12'(ch_r - in_data.pos_y);

  // sequencer, operands of the shared unit are launched from here
  always_comb begin
    du_start = 1'b0;
    du_op = DU_DIV;
    du_a = '0;
    du_b = '0;
    case (state_r)
      S_M2: begin
        du_start = 1'b1;
        du_op = DU_SQRT;
        du_a = outside_r ? (m2_r << (2 * SqGuard)) : ((r2 - m2_r) << (2 * SqGuard));
      end
      S_D0: begin
        du_start = 1'b1;
        du_a = outside_r ? mag(64'(dx) <<< (FracBits + SqGuard))
                         : mag(64'(dx) <<< FracBits);
        du_b = outside_r ? nrm_r : 64'(rad_e);
      end
      S_D1: begin
        du_start = 1'b1;
        du_a = outside_r ? mag(64'(dy) <<< (FracBits + SqGuard))
                         : mag(64'(dy) <<< FracBits);
        du_b = outside_r ? nrm_r : 64'(rad_e);
      end
      S_D2: begin
        du_start = 1'b1;
        du_a = nrm_r << FracBits;
        du_b = 64'(rad_e) << SqGuard;
      end
      S_AS: begin
        if (step_r == 4'd1) begin
          du_start = 1'b1;
          du_op = DU_SQRT;
          du_a = 64'(acc_sum);
        end
      end
      S_FX: begin
        du_start = 1'b1;
        du_a = mag(64'(pr_r[1]) <<< FracBits);
        du_b = nrm_r;
      end
      S_FY: begin
        du_start = 1'b1;
        du_a = mag(64'(pr_r[0]) <<< FracBits);
        du_b = nrm_r;
      end
      default: ;
    endcase
  end

  logic signed [63:0] qv;
  assign qv = neg_r ? -$signed(du_res) : $signed(du_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cx_r <= '0; cy_r <= '0; rad_r <= 12'd256; ch_r <= '0; flip_r <= 1'b0;
      cur_x_r <= '0; cur_y_r <= '0;
      for (int i = 0; i < 3; i++) pp_r[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        pr_r[i] <= (i == 3) ? One : '0;
        cr_r[i] <= (i == 3) ? One : '0;
      end
      drag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: cx_r <= cfg_data;
          CFG_CENTER_Y: cy_r <= cfg_data;
          CFG_RADIUS: rad_r <= cfg_data;
          CFG_CANVAS_H: ch_r <= cfg_data;
          CFG_FLIP_Y: flip_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data.req_type;
            if (in_data.req_type == REQ_PRESS || in_data.req_type == REQ_MOVE) begin
              cur_x_r <= in_data.pos_x;
              cur_y_r <= flip_r ? fy_in : in_data.pos_y;
              state_r <= S_CUR;
            end else begin
              if (in_data.req_type == REQ_RELEASE) drag_r <= 1'b0;
              acc_r <= '0;
              step_r <= '0;
              state_r <= S_AS;
            end
          end
        end
        S_CUR: begin
          m2_r <= 64'(26'(dx) * 26'(dx)) + 64'(26'(dy) * 26'(dy));
          state_r <= S_MW;
        end
        S_MW: begin
          outside_r <= (m2_r > r2);
          state_r <= S_M2;
        end
        S_M2: state_r <= S_SQW;
        S_SQW: if (!du_busy) begin nrm_r <= du_res; state_r <= S_D0; end
        S_D0: begin neg_r <= dx[12]; state_r <= S_D0W; end
        S_D0W: if (!du_busy) begin t_r[0] <= clampq(qv); state_r <= S_D1; end
        S_D1: begin neg_r <= dy[12]; state_r <= S_D1W; end
        S_D1W: if (!du_busy) begin
          t_r[1] <= clampq(qv);
          if (outside_r) begin
            t_r[2] <= '0;
            state_r <= S_SQ;
          end else state_r <= S_D2;
        end
        S_D2: begin neg_r <= 1'b0; state_r <= S_D2W; end
        S_D2W: if (!du_busy) begin t_r[2] <= clampq(qv); state_r <= S_SQ; end
        S_SQ: begin
          // sphere point ready: apply request
          acc_r <= '0;
          step_r <= '0;
          idx_r <= '0;
          if (req_r == REQ_PRESS) begin
            for (int i = 0; i < 3; i++) pp_r[i] <= t_r[i];
            for (int i = 0; i < 4; i++) pr_r[i] <= cr_r[i];
            drag_r <= 1'b1;
            state_r <= S_AS;
          end else if (drag_r) state_r <= S_CROSS;
          else state_r <= S_AS;
        end
        S_CROSS: begin
          if (last_cross) begin
            d_r[idx_r] <= clampq(rnd(acc_sum));
            acc_r <= '0;
            step_r <= '0;
            if (idx_r == 2'd3) state_r <= S_QMUL;
            idx_r <= idx_r + 2'd1;
          end else begin
            acc_r <= acc_sum;
            step_r <= step_r + 4'd1;
          end
        end
        S_QMUL: begin
          if (last_qmul) begin
            cr_r[idx_r] <= clampq(rnd(acc_sum));
            acc_r <= '0;
            step_r <= '0;
            if (idx_r == 2'd3) state_r <= S_AS;
            idx_r <= idx_r + 2'd1;
          end else begin
            acc_r <= acc_sum;
            step_r <= step_r + 4'd1;
          end
        end
        S_AS: begin
          if (step_r == 4'd1) state_r <= S_ASW;
          else begin
            acc_r <= acc_sum;
            step_r <= 4'd1;
          end
        end
        S_ASW: if (!du_busy) begin
          nrm_r <= du_res;
          if (du_res == '0) begin
            fx_r <= '0;
            fy_r <= One;
            acc_r <= '0; step_r <= '0; idx_r <= '0;
            state_r <= S_ARC;
          end else state_r <= S_FX;
        end
        S_FX: begin neg_r <= ~pr_r[1][31] && (pr_r[1] != '0); state_r <= S_FXW; end
        S_FXW: if (!du_busy) begin fx_r <= clampq(qv); state_r <= S_FY; end
        S_FY: begin neg_r <= pr_r[0][31]; state_r <= S_FYW; end
        S_FYW: if (!du_busy) begin
          fy_r <= clampq(qv);
          acc_r <= '0; step_r <= '0; idx_r <= '0;
          state_r <= S_ARC;
        end
        S_ARC: begin
          if (step_r == 4'd1) begin
            case (idx_r)
              2'd0: ex_r <= clampq(rnd(acc_sum));
              2'd1: ey_r <= clampq(rnd(acc_sum));
              default: ez_r <= clampq(rnd(acc_sum));
            endcase
            acc_r <= '0;
            step_r <= '0;
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd2) begin
              if (pr_r[3][31]) begin fx_r <= -fx_r; fy_r <= -fy_r; end
              out_valid_r <= 1'b1;
              state_r <= S_OUT;
            end
          end else begin
            acc_r <= acc_sum;
            step_r <= 4'd1;
          end
        end
        S_OUT: if (!out_stall) begin out_valid_r <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  always_comb begin
    out_data.rot_x = out16(cr_r[0]);
    out_data.rot_y = out16(cr_r[1]);
    out_data.rot_z = out16(cr_r[2]);
    out_data.rot_w = out16(cr_r[3]);
    out_data.arc_start_x = out16(fx_r);
    out_data.arc_start_y = out16(fy_r);
    out_data.arc_end_x = out16(ex_r);
    out_data.arc_end_y = out16(ey_r);
    out_data.arc_end_z = out16(ez_r);
    out_data.is_dragging = drag_r;
  end

  `ADR_ASSERT(a_valid_busy, !(out_valid && !in_stall), "result valid while accepting")
  `ADR_ASSERT(a_du_idle_start, !(du_start && du_busy), "shared unit started while busy")
  `ADR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "no stall after accept")
endmodule
`default_nettype wire
